/* sv/pce_pkg.sv */
// shared types, codes and arithmetic helpers for the palette code converter
package pce_pkg;

    localparam logic [1:0] FUNC_TEXT    = 2'd0;
    localparam logic [1:0] FUNC_GRAPH64 = 2'd1;

    localparam logic [1:0] REG_BLANK      = 2'd0;
    localparam logic [1:0] REG_HALF_TEXT  = 2'd1;
    localparam logic [1:0] REG_HALF_GRAPH = 2'd2;

    localparam logic [7:0] TEXT_SCALE   = 8'h55;
    localparam logic [7:0] GRAPH_SCALE  = 8'h11;
    localparam logic [7:0] BLANK_RESET  = 8'd0;
    localparam logic [7:0] FACTOR_RESET = 8'd255;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [15:0] text_red;
        logic [15:0] text_green;
        logic [15:0] text_blue;
        logic [15:0] graph_red;
        logic [15:0] graph_green;
        logic [15:0] graph_blue;
    } t_prod;

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

/* sv/pce_expand.sv */
// first stage: channel expansion, blank floor and mirror flag
module pce_expand (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    input  logic [11:0]         i_code,
    input  logic [5:0]          i_index,
    input  logic [7:0]          i_blank,
    output logic                o_valid,
    input  logic                i_ready,
    output pce_pkg::t_rgb       o_rgb,
    output logic                o_mirror
);

    logic          r_valid;
    pce_pkg::t_rgb r_rgb;
    logic          r_mirror;
    pce_pkg::t_rgb n_rgb;
    logic          n_mirror;
    logic          w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        if (i_func == pce_pkg::FUNC_TEXT) begin
            n_rgb.blue  = 8'({6'd0, i_code[1:0]} * pce_pkg::TEXT_SCALE);
            n_rgb.red   = 8'({6'd0, i_code[3:2]} * pce_pkg::TEXT_SCALE);
            n_rgb.green = 8'({6'd0, i_code[5:4]} * pce_pkg::TEXT_SCALE);
        end else begin
            n_rgb.blue  = 8'({4'd0, i_code[3:0]}  * pce_pkg::GRAPH_SCALE);
            n_rgb.red   = 8'({4'd0, i_code[7:4]}  * pce_pkg::GRAPH_SCALE);
            n_rgb.green = 8'({4'd0, i_code[11:8]} * pce_pkg::GRAPH_SCALE);
        end
        if (n_rgb.red < i_blank && n_rgb.green < i_blank && n_rgb.blue < i_blank) begin
            n_rgb.red   = i_blank;
            n_rgb.green = i_blank;
            n_rgb.blue  = i_blank;
        end
        n_mirror = (i_func == pce_pkg::FUNC_GRAPH64) && (i_index[2:0] == i_index[5:3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rgb    <= n_rgb;
            r_mirror <= n_mirror;
        end
    end

    assign o_valid  = r_valid;
    assign o_rgb    = r_rgb;
    assign o_mirror = r_mirror;

endmodule

/* sv/pce_scale.sv */
// second stage: channel times dimming factor products
module pce_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pce_pkg::t_rgb       i_rgb,
    input  logic                i_mirror,
    input  logic [7:0]          i_half_text,
    input  logic [7:0]          i_half_graph,
    output logic                o_valid,
    input  logic                i_ready,
    output pce_pkg::t_rgb       o_rgb,
    output pce_pkg::t_prod      o_prod,
    output logic                o_mirror
);

    logic           r_valid;
    pce_pkg::t_rgb  r_rgb;
    pce_pkg::t_prod r_prod;
    logic           r_mirror;
    pce_pkg::t_prod n_prod;
    logic           w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_prod.text_red    = i_rgb.red   * i_half_text;
        n_prod.text_green  = i_rgb.green * i_half_text;
        n_prod.text_blue   = i_rgb.blue  * i_half_text;
        n_prod.graph_red   = i_rgb.red   * i_half_graph;
        n_prod.graph_green = i_rgb.green * i_half_graph;
        n_prod.graph_blue  = i_rgb.blue  * i_half_graph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rgb    <= i_rgb;
            r_prod   <= n_prod;
            r_mirror <= i_mirror;
        end
    end

    assign o_valid  = r_valid;
    assign o_rgb    = r_rgb;
    assign o_prod   = r_prod;
    assign o_mirror = r_mirror;

endmodule

/* sv/pce_div.sv */
// third stage: divide products by 255 into the output register
module pce_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pce_pkg::t_rgb       i_rgb,
    input  pce_pkg::t_prod      i_prod,
    input  logic                i_mirror,
    output logic                o_valid,
    input  logic                i_ready,
    output pce_pkg::t_rgb       o_rgb,
    output pce_pkg::t_rgb       o_text_dim,
    output pce_pkg::t_rgb       o_graph_dim,
    output logic                o_mirror
);

    logic          r_valid;
    pce_pkg::t_rgb r_rgb;
    pce_pkg::t_rgb r_text_dim;
    pce_pkg::t_rgb r_graph_dim;
    logic          r_mirror;
    pce_pkg::t_rgb n_text_dim;
    pce_pkg::t_rgb n_graph_dim;
    logic          w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_text_dim.red    = pce_pkg::div255(i_prod.text_red);
        n_text_dim.green  = pce_pkg::div255(i_prod.text_green);
        n_text_dim.blue   = pce_pkg::div255(i_prod.text_blue);
        n_graph_dim.red   = pce_pkg::div255(i_prod.graph_red);
        n_graph_dim.green = pce_pkg::div255(i_prod.graph_green);
        n_graph_dim.blue  = pce_pkg::div255(i_prod.graph_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rgb       <= i_rgb;
            r_text_dim  <= n_text_dim;
            r_graph_dim <= n_graph_dim;
            r_mirror    <= i_mirror;
        end
    end

    assign o_valid     = r_valid;
    assign o_rgb       = r_rgb;
    assign o_text_dim  = r_text_dim;
    assign o_graph_dim = r_graph_dim;
    assign o_mirror    = r_mirror;

endmodule

/* sv/palette_code_to_rgb_converter.sv */
// Palette code to RGB converter: turns one palette code per word into 8-bit
// RGB with a blank floor, two dimmed copies and a mirror flag.
// Input channel s_axis: tuser carries the mode selector, tdata the code and
// the palette entry number. Output channel m_axis: tdata carries the nine
// color bytes, tuser the mirror flag.
// Configuration: i_cfg_wr_en writes i_cfg_wdata into register i_cfg_addr
// (0 blank level, 1 text dim factor, 2 graphics dim factor) at the clock
// edge; other addresses are ignored. Write only while the block is empty.
// The registered stages from input accept to output are, in order:
// expansion and floor, the six 8x8 products, then the divide by 255. One
// word is taken per cycle for as long as the receiver keeps m_axis_tready high.
// Each stage holds while the stage after it is full and stalled, so a
// stalled receiver still lets up to two more words be taken before
// s_axis_tready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets the blank level to 0 and
// both dim factors to 255.
module palette_code_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // color_code, entry_index, zero pad
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red, green, blue, text_dim_red/green/blue, graph_dim_red/green/blue
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser,   // mirror_hit
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    logic [7:0]     r_blank;
    logic [7:0]     r_half_text;
    logic [7:0]     r_half_graph;

    logic           w_v1;
    logic           w_rdy2;
    pce_pkg::t_rgb  w_rgb1;
    logic           w_mir1;
    logic           w_v2;
    logic           w_rdy3;
    pce_pkg::t_rgb  w_rgb2;
    pce_pkg::t_prod w_prod2;
    logic           w_mir2;
    pce_pkg::t_rgb  w_rgb3;
    pce_pkg::t_rgb  w_text3;
    pce_pkg::t_rgb  w_graph3;
    logic           w_mir3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank      <= pce_pkg::BLANK_RESET;
            r_half_text  <= pce_pkg::FACTOR_RESET;
            r_half_graph <= pce_pkg::FACTOR_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                pce_pkg::REG_BLANK:      r_blank      <= i_cfg_wdata;
                pce_pkg::REG_HALF_TEXT:  r_half_text  <= i_cfg_wdata;
                pce_pkg::REG_HALF_GRAPH: r_half_graph <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pce_expand u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_func   (s_axis_tuser),
        .i_code   (s_axis_tdata[11:0]),
        .i_index  (s_axis_tdata[17:12]),
        .i_blank  (r_blank),
        .o_valid  (w_v1),
        .i_ready  (w_rdy2),
        .o_rgb    (w_rgb1),
        .o_mirror (w_mir1)
    );

    pce_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_v1),
        .o_ready      (w_rdy2),
        .i_rgb        (w_rgb1),
        .i_mirror     (w_mir1),
        .i_half_text  (r_half_text),
        .i_half_graph (r_half_graph),
        .o_valid      (w_v2),
        .i_ready      (w_rdy3),
        .o_rgb        (w_rgb2),
        .o_prod       (w_prod2),
        .o_mirror     (w_mir2)
    );

    pce_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_v2),
        .o_ready     (w_rdy3),
        .i_rgb       (w_rgb2),
        .i_prod      (w_prod2),
        .i_mirror    (w_mir2),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_rgb       (w_rgb3),
        .o_text_dim  (w_text3),
        .o_graph_dim (w_graph3),
        .o_mirror    (w_mir3)
    );

    assign m_axis_tdata = {w_graph3.blue, w_graph3.green, w_graph3.red,
                           w_text3.blue, w_text3.green, w_text3.red,
                           w_rgb3.blue, w_rgb3.green, w_rgb3.red};
    assign m_axis_tuser = w_mir3;

    // a dimmed channel never exceeds its source channel
    a_text_dim_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_text3.red <= w_rgb3.red && w_text3.green <= w_rgb3.green
                           && w_text3.blue <= w_rgb3.blue))
        else $error("text dim above channel");

    a_graph_dim_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_graph3.red <= w_rgb3.red && w_graph3.green <= w_rgb3.green
                           && w_graph3.blue <= w_rgb3.blue))
        else $error("graphics dim above channel");

    // input only backs up when every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_v1 && w_v2 && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with a free stage");

    // a word held in the first stage under stall is still there next cycle
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v1 && !w_rdy2) |=> w_v1)
        else $error("first stage word lost");

endmodule
